@@ design/madt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_pkg
// Shared types and constants of the interrupt-controller table parser.
// ----------------------------------------------------------------------------
package madt_pkg;

  localparam int MAX_PROCESSORS     = 64;
  localparam int MAX_IO_CONTROLLERS = 16;
  localparam int MAX_IRQ_OVERRIDES  = 16;

  localparam int PROC_CNT_W = $clog2(MAX_PROCESSORS + 1);
  localparam int IO_CNT_W   = $clog2(MAX_IO_CONTROLLERS + 1);
  localparam int OVR_CNT_W  = $clog2(MAX_IRQ_OVERRIDES + 1);
  localparam int ENABLED_W  = 7;

  localparam int HDR_W = 6;
  localparam logic [HDR_W-1:0] HEADER_LEN    = 6'd44;
  localparam logic [HDR_W-1:0] HDR_OFF_ADDR  = 6'd36;
  localparam logic [HDR_W-1:0] HDR_OFF_FLAGS = 6'd40;

  localparam int ENTRY_BUF_N = 16;
  localparam int ENTRY_IDX_W = $clog2(ENTRY_BUF_N);

  localparam logic [7:0] ENT_PROC = 8'd0;
  localparam logic [7:0] ENT_IO   = 8'd1;
  localparam logic [7:0] ENT_OVR  = 8'd2;
  localparam logic [7:0] ENT_ADDR = 8'd5;
  localparam logic [7:0] ENT_X2   = 8'd9;

  localparam logic [7:0] LEN_MIN_ENTRY = 8'd2;
  localparam logic [7:0] LEN_PROC      = 8'd8;
  localparam logic [7:0] LEN_IO        = 8'd12;
  localparam logic [7:0] LEN_OVR       = 8'd10;
  localparam logic [7:0] LEN_ADDR      = 8'd12;
  localparam logic [7:0] LEN_X2        = 8'd16;

  localparam logic [1:0] KIND_PROC   = 2'd0;
  localparam logic [1:0] KIND_IO     = 2'd1;
  localparam logic [1:0] KIND_OVR    = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BAD   = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam int RBUF_DEPTH = 4;
  localparam int RBUF_AW    = $clog2(RBUF_DEPTH);

  typedef struct packed {
    logic [7:0] table_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]           record_kind;
    logic [31:0]          word_a;
    logic [31:0]          word_b;
    logic [7:0]           byte_id;
    logic [7:0]           source_irq;
    logic                 flag_enabled;
    logic                 flag_online_capable;
    logic                 flag_wide;
    logic [1:0]           status;
    logic [ENABLED_W-1:0] enabled_count;
    logic                 last_result;
  } out_t;

  typedef struct packed {
    logic [HDR_W-1:0]      header_offset;
    logic [7:0]            entry_type;
    logic [7:0]            entry_length;
    logic [7:0]            entry_position;
    logic [31:0]           local_address;
    logic                  compat_flag;
    logic [PROC_CNT_W-1:0] processor_count;
    logic [PROC_CNT_W-1:0] enabled_processors;
    logic [IO_CNT_W-1:0]   io_count;
    logic [OVR_CNT_W-1:0]  override_count;
    logic                  failed;
  } state_t;

  typedef logic [ENTRY_BUF_N-1:0][7:0] bytes_t;

  typedef struct packed {
    logic                   en;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [7:0]             data;
  } buf_wr_t;

  typedef struct packed {
    logic rec_vld;
    logic stat_vld;
  } emit_t;

endpackage

@@ design/madt_record_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_record_parser_unit
// Streaming parser for an interrupt-controller description table.
//
// Input channel (in_valid/in_stall/in_data): one table byte per request,
// offset zero first, last_byte set on the final byte.
// Result channel (out_valid/out_stall/out_data): decoded processor, io
// controller and irq override records, then one final status record on the
// last byte; last_result marks the final result caused by a byte.
// Each result is written into the result queue when its byte is accepted and is offered from there.
// Throughput: one byte per cycle while in_stall is low; a byte yields at
// most two results, which sit in a four-entry result queue drained at one
// per cycle while out_stall is low, so in_stall rises only when the queue
// holds more than two results. Reset clears the parser state, but not the
// entry byte buffer, and empties the queue. A stalled receiver fills the
// queue and then stalls the input side; nothing is dropped. After the last
// byte the parser is back in its reset state for the next table.
// ----------------------------------------------------------------------------
module madt_record_parser_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  madt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output madt_pkg::out_t out_data
);

  madt_pkg::state_t  st_r, st_nxt;
  madt_pkg::bytes_t  eb_r;
  madt_pkg::buf_wr_t buf_wr;
  madt_pkg::emit_t   emit;
  madt_pkg::out_t    rec, stat;
  madt_pkg::out_t    push0;
  logic [1:0]        push_n;
  logic              accept;

  assign accept = in_valid && !in_stall;

  madt_step u_step (
    .st          (st_r),
    .entry_bytes (eb_r),
    .in_data     (in_data),
    .st_nxt      (st_nxt),
    .buf_wr      (buf_wr),
    .emit        (emit),
    .rec         (rec),
    .stat        (stat)
  );

  always_comb begin
    push0  = emit.rec_vld ? rec : stat;
    push_n = accept ? ({1'b0, emit.rec_vld} + {1'b0, emit.stat_vld}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && buf_wr.en) begin
      eb_r[buf_wr.idx] <= buf_wr.data;
    end
  end

  madt_rbuf u_rbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_n      (push_n),
    .push0       (push0),
    .push1       (stat),
    .almost_full (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

@@ design/madt_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_step
// Next-state and result decode for one table byte.
// ----------------------------------------------------------------------------
module madt_step (
  input  madt_pkg::state_t  st,
  input  madt_pkg::bytes_t  entry_bytes,
  input  madt_pkg::in_t     in_data,
  output madt_pkg::state_t  st_nxt,
  output madt_pkg::buf_wr_t buf_wr,
  output madt_pkg::emit_t   emit,
  output madt_pkg::out_t    rec,
  output madt_pkg::out_t    stat
);

  function automatic logic [31:0] get32(madt_pkg::bytes_t b,
                                        logic [madt_pkg::ENTRY_IDX_W-1:0] off);
    logic [madt_pkg::ENTRY_IDX_W-1:0] o1, o2, o3;
    o1 = off + madt_pkg::ENTRY_IDX_W'(1);
    o2 = off + madt_pkg::ENTRY_IDX_W'(2);
    o3 = off + madt_pkg::ENTRY_IDX_W'(3);
    return {b[o3], b[o2], b[o1], b[off]};
  endfunction

  always_comb begin
    madt_pkg::bytes_t     view;
    logic [7:0]           byte_v;
    logic [7:0]           pos;
    logic [7:0]           len;
    logic [1:0]           lane;
    logic [31:0]          lo;
    logic [31:0]          hi;
    logic                 proc_hit;
    logic                 proc_en;
    logic                 proc_on;
    logic                 proc_wide;
    logic [31:0]          proc_a;
    logic [31:0]          proc_b;

    byte_v    = in_data.table_byte;
    st_nxt    = st;
    view      = entry_bytes;
    pos       = st.entry_position;
    len       = st.entry_length;
    lane      = '0;
    lo        = '0;
    hi        = '0;
    proc_hit  = 1'b0;
    proc_en   = 1'b0;
    proc_on   = 1'b0;
    proc_wide = 1'b0;
    proc_a    = '0;
    proc_b    = '0;
    buf_wr.en   = 1'b0;
    buf_wr.idx  = pos[madt_pkg::ENTRY_IDX_W-1:0];
    buf_wr.data = byte_v;
    emit.rec_vld  = 1'b0;
    emit.stat_vld = 1'b0;
    rec  = '0;
    stat = '0;

    if (!st.failed) begin
      if (st.header_offset < madt_pkg::HEADER_LEN) begin
        if (st.header_offset >= madt_pkg::HDR_OFF_ADDR &&
            st.header_offset <= madt_pkg::HDR_OFF_ADDR + 6'd3) begin
          lane = 2'(st.header_offset - madt_pkg::HDR_OFF_ADDR);
          st_nxt.local_address[lane*8 +: 8] = st.local_address[lane*8 +: 8] | byte_v;
        end else if (st.header_offset == madt_pkg::HDR_OFF_FLAGS) begin
          st_nxt.compat_flag = byte_v[0];
        end
        st_nxt.header_offset = st.header_offset + 6'd1;
        if (in_data.last_byte && (st.header_offset + 6'd1) < madt_pkg::HEADER_LEN) begin
          st_nxt.failed = 1'b1;
        end
      end else begin
        if (pos < 8'(madt_pkg::ENTRY_BUF_N)) begin
          buf_wr.en = 1'b1;
          view[pos[madt_pkg::ENTRY_IDX_W-1:0]] = byte_v;
        end
        if (pos == 8'd0) begin
          st_nxt.entry_type = byte_v;
          if (in_data.last_byte) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.entry_position = 8'd1;
          end
        end else begin
          if (pos == 8'd1) begin
            len = byte_v;
            st_nxt.entry_length = byte_v;
          end
          if (pos == 8'd1 && byte_v < madt_pkg::LEN_MIN_ENTRY) begin
            st_nxt.failed = 1'b1;
          end else if ({1'b0, pos} + 9'd1 == {1'b0, len}) begin
            st_nxt.entry_position = 8'd0;
            lo = get32(view, madt_pkg::ENTRY_IDX_W'(4));
            hi = get32(view, madt_pkg::ENTRY_IDX_W'(8));
            if (st.entry_type == madt_pkg::ENT_PROC && len >= madt_pkg::LEN_PROC) begin
              proc_hit = 1'b1;
              proc_a   = {24'd0, view[3]};
              proc_b   = {24'd0, view[2]};
              proc_en  = view[4][0];
              proc_on  = view[4][1];
            end else if (st.entry_type == madt_pkg::ENT_X2 && len >= madt_pkg::LEN_X2) begin
              proc_hit  = 1'b1;
              proc_wide = 1'b1;
              proc_a    = lo;
              proc_b    = get32(view, madt_pkg::ENTRY_IDX_W'(12));
              proc_en   = view[8][0];
              proc_on   = view[8][1];
            end else if (st.entry_type == madt_pkg::ENT_IO && len >= madt_pkg::LEN_IO) begin
              if (st.io_count < madt_pkg::IO_CNT_W'(madt_pkg::MAX_IO_CONTROLLERS)) begin
                st_nxt.io_count = st.io_count + madt_pkg::IO_CNT_W'(1);
                emit.rec_vld    = 1'b1;
                rec.record_kind = madt_pkg::KIND_IO;
                rec.word_a      = lo;
                rec.word_b      = hi;
                rec.byte_id     = view[2];
              end
            end else if (st.entry_type == madt_pkg::ENT_OVR && len >= madt_pkg::LEN_OVR) begin
              if (st.override_count < madt_pkg::OVR_CNT_W'(madt_pkg::MAX_IRQ_OVERRIDES)) begin
                st_nxt.override_count = st.override_count + madt_pkg::OVR_CNT_W'(1);
                emit.rec_vld    = 1'b1;
                rec.record_kind = madt_pkg::KIND_OVR;
                rec.word_a      = lo;
                rec.word_b      = {16'd0, view[9], view[8]};
                rec.byte_id     = view[2];
                rec.source_irq  = view[3];
              end
            end else if (st.entry_type == madt_pkg::ENT_ADDR && len >= madt_pkg::LEN_ADDR) begin
              if (hi == 32'd0 && lo != 32'd0 && lo[11:0] == 12'd0) begin
                st_nxt.local_address = lo;
              end
            end
            if (proc_hit &&
                st.processor_count < madt_pkg::PROC_CNT_W'(madt_pkg::MAX_PROCESSORS)) begin
              st_nxt.processor_count = st.processor_count + madt_pkg::PROC_CNT_W'(1);
              if (proc_en) begin
                st_nxt.enabled_processors = st.enabled_processors
                                          + madt_pkg::PROC_CNT_W'(1);
              end
              emit.rec_vld            = 1'b1;
              rec.record_kind         = madt_pkg::KIND_PROC;
              rec.word_a              = proc_a;
              rec.word_b              = proc_b;
              rec.flag_enabled        = proc_en;
              rec.flag_online_capable = proc_on;
              rec.flag_wide           = proc_wide;
            end
          end else if (in_data.last_byte) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.entry_position = pos + 8'd1;
          end
        end
      end
    end

    rec.enabled_count = madt_pkg::ENABLED_W'(st_nxt.enabled_processors);
    rec.last_result   = !in_data.last_byte;

    if (in_data.last_byte) begin
      emit.stat_vld      = 1'b1;
      stat.record_kind   = madt_pkg::KIND_STATUS;
      stat.word_a        = st_nxt.local_address;
      stat.flag_wide     = st_nxt.compat_flag;
      stat.enabled_count = madt_pkg::ENABLED_W'(st_nxt.enabled_processors);
      stat.last_result   = 1'b1;
      if (st_nxt.failed) begin
        stat.status = madt_pkg::STAT_BAD;
      end else if (st_nxt.processor_count == '0 || st_nxt.enabled_processors == '0 ||
                   st_nxt.local_address == 32'd0) begin
        stat.status = madt_pkg::STAT_EMPTY;
      end else begin
        stat.status = madt_pkg::STAT_OK;
      end
      st_nxt = '0;
    end
  end

endmodule

@@ design/madt_rbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_rbuf
// Result queue: takes up to two results per cycle, hands out one unless out_stall is high.
// ----------------------------------------------------------------------------
module madt_rbuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_n,
  input  madt_pkg::out_t push0,
  input  madt_pkg::out_t push1,
  output logic           almost_full,
  output logic           out_valid,
  input  logic           out_stall,
  output madt_pkg::out_t out_data
);

  madt_pkg::out_t                mem [madt_pkg::RBUF_DEPTH];
  logic [madt_pkg::RBUF_AW-1:0]  wp_r, wp_nxt;
  logic [madt_pkg::RBUF_AW-1:0]  rp_r, rp_nxt;
  logic [madt_pkg::RBUF_AW:0]    cnt_r, cnt_nxt;
  logic                          pop;

  assign out_valid   = (cnt_r != '0);
  assign out_data    = mem[rp_r];
  assign pop         = out_valid && !out_stall;
  assign almost_full = (cnt_r > (madt_pkg::RBUF_AW + 1)'(madt_pkg::RBUF_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + madt_pkg::RBUF_AW'(push_n);
    rp_nxt  = rp_r + madt_pkg::RBUF_AW'(pop);
    cnt_nxt = cnt_r + (madt_pkg::RBUF_AW + 1)'(push_n)
                    - (madt_pkg::RBUF_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wp_r + madt_pkg::RBUF_AW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/madt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_checker
// Port-level checks of the table parser, bound to the top level.
// ----------------------------------------------------------------------------
module madt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input madt_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result offered or input stalled right after reset");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind == madt_pkg::KIND_STATUS |-> out_data.last_result)
    else $error("final status not marked as last result");

  a_record_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind != madt_pkg::KIND_STATUS
      |-> out_data.status == madt_pkg::STAT_OK && out_data.word_b[31:16] == 16'd0
          || out_data.record_kind == madt_pkg::KIND_PROC
          || out_data.record_kind == madt_pkg::KIND_IO)
    else $error("record result carries a status or wide flags");

  a_enabled_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind == madt_pkg::KIND_PROC && out_data.flag_enabled
      |-> out_data.enabled_count != '0)
    else $error("enabled processor without enabled count");

endmodule

bind madt_record_parser_unit madt_checker u_madt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
